### sv/pab_pkg.sv
// shared types, constants and helpers for the proximity alarm blinker
// no dependencies

package pab_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DistW     = 16;
  localparam int unsigned ColourW   = 24;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgAddrW  = 3;

  localparam logic [7:0]       LedFull        = 8'd255;
  localparam logic [ColourW-1:0] LedYellow    = {LedFull, LedFull, 8'd0};
  localparam logic [ColourW-1:0] LedDark      = '0;
  localparam logic [TimeW-1:0] TestDurationMs = TimeW'(3000);

  localparam logic [ColourW-1:0] ColourAReset   = 24'hFF0000;
  localparam logic [ColourW-1:0] ColourBReset   = 24'h0000FF;
  localparam logic [TimeW-1:0]   BlinkReset     = TimeW'(250);
  localparam logic [DistW-1:0]   TriggerReset   = DistW'(1600);
  localparam logic [TimeW-1:0]   TimeoutReset   = TimeW'(3000);

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_ON     = 2'd1,
    KIND_OFF    = 2'd2,
    KIND_TEST   = 2'd3
  } kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_COLOUR_A  = 3'd0,
    CFG_COLOUR_B  = 3'd1,
    CFG_BLINK     = 3'd2,
    CFG_TRIGGER   = 3'd3,
    CFG_TIMEOUT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    MODE_OFF   = 4'b0001,
    MODE_WATCH = 4'b0010,
    MODE_ON    = 4'b0100,
    MODE_TEST  = 4'b1000
  } mode_e;

  localparam logic [1:0] StateOff   = 2'd0;
  localparam logic [1:0] StateWatch = 2'd1;
  localparam logic [1:0] StateOn    = 2'd2;
  localparam logic [1:0] StateTest  = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TimeW-1:0] now_ms;
    logic [DistW-1:0] distance;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] alarm_state;
  } out_beat_t;

  typedef struct packed {
    logic [ColourW-1:0] colour_a;
    logic [ColourW-1:0] colour_b;
    logic [TimeW-1:0]   blink_period_ms;
    logic [DistW-1:0]   trigger_distance;
    logic [TimeW-1:0]   clear_timeout_ms;
  } cfg_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_OFF:   c = StateOff;
      MODE_WATCH: c = StateWatch;
      MODE_ON:    c = StateOn;
      MODE_TEST:  c = StateTest;
      default:    c = StateOff;
    endcase
    return c;
  endfunction

endpackage

### sv/pab_cfg_regs.sv
// configuration registers of the proximity alarm blinker
// depends on pab_pkg

module pab_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pab_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [pab_pkg::CfgDataW-1:0]     cfg_wdata_i,
  output pab_pkg::cfg_t                    cfg_o
);
  import pab_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_COLOUR_A: cfg_d.colour_a         = cfg_wdata_i[ColourW-1:0];
        CFG_COLOUR_B: cfg_d.colour_b         = cfg_wdata_i[ColourW-1:0];
        CFG_BLINK:    cfg_d.blink_period_ms  = cfg_wdata_i[TimeW-1:0];
        CFG_TRIGGER:  cfg_d.trigger_distance = cfg_wdata_i[DistW-1:0];
        CFG_TIMEOUT:  cfg_d.clear_timeout_ms = cfg_wdata_i[TimeW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.colour_a         <= ColourAReset;
      cfg_q.colour_b         <= ColourBReset;
      cfg_q.blink_period_ms  <= BlinkReset;
      cfg_q.trigger_distance <= TriggerReset;
      cfg_q.clear_timeout_ms <= TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/pab_core.sv
// alarm state machine, timers and led selection, one beat per cycle in which step_i is high
// depends on pab_pkg

module pab_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pab_pkg::in_beat_t   beat_i,
  input  pab_pkg::cfg_t       cfg_i,
  output pab_pkg::out_beat_t  result_o
);
  import pab_pkg::*;

  mode_e              mode_q, mode_d, mode_v;
  logic               on_pend_q, on_pend_d;
  logic               off_pend_q, off_pend_d;
  logic               sel_q, sel_d;
  logic [TimeW-1:0]   toggle_t_q, toggle_t_d;
  logic [TimeW-1:0]   detect_t_q, detect_t_d;
  logic [TimeW-1:0]   test_t_q, test_t_d;
  logic [TimeW-1:0]   update_t_q, update_t_d;
  logic [ColourW-1:0] led_q, led_d;

  logic [TimeW-1:0]   since_toggle, since_detect, since_test;
  logic               near;

  assign since_toggle = beat_i.now_ms - toggle_t_q;
  assign since_detect = beat_i.now_ms - detect_t_q;
  assign since_test   = beat_i.now_ms - test_t_q;
  assign near         = beat_i.distance <= cfg_i.trigger_distance;

  always_comb begin
    mode_d     = mode_q;
    on_pend_d  = on_pend_q;
    off_pend_d = off_pend_q;
    sel_d      = sel_q;
    toggle_t_d = toggle_t_q;
    detect_t_d = detect_t_q;
    test_t_d   = test_t_q;
    update_t_d = update_t_q;
    led_d      = led_q;
    mode_v     = mode_q;
    case (kind_e'(beat_i.kind))
      KIND_UPDATE: begin
        update_t_d = beat_i.now_ms;
        if (on_pend_q) begin
          mode_v = MODE_WATCH;
        end
        if (off_pend_q) begin
          mode_v = MODE_OFF;
        end
        on_pend_d  = 1'b0;
        off_pend_d = 1'b0;
        mode_d     = mode_v;
        unique case (mode_v)
          MODE_OFF: begin
            led_d = LedDark;
          end
          MODE_WATCH: begin
            if (near) begin
              mode_d     = MODE_ON;
              detect_t_d = beat_i.now_ms;
            end
          end
          MODE_ON: begin
            if (since_toggle >= cfg_i.blink_period_ms) begin
              sel_d      = !sel_q;
              led_d      = sel_q ? cfg_i.colour_a : cfg_i.colour_b;
              toggle_t_d = beat_i.now_ms;
            end
            if (!near) begin
              if (since_detect >= cfg_i.clear_timeout_ms) begin
                mode_d = MODE_WATCH;
                led_d  = LedDark;
              end
            end else begin
              detect_t_d = beat_i.now_ms;
            end
          end
          MODE_TEST: begin
            led_d = LedYellow;
            if (since_test >= TestDurationMs) begin
              mode_d = MODE_WATCH;
              led_d  = LedDark;
            end
          end
          default: begin
            mode_d = MODE_OFF;
          end
        endcase
      end
      KIND_ON:  on_pend_d  = 1'b1;
      KIND_OFF: off_pend_d = 1'b1;
      default: begin
        mode_d   = MODE_TEST;
        test_t_d = update_t_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OFF;
      on_pend_q  <= 1'b0;
      off_pend_q <= 1'b0;
      sel_q      <= 1'b0;
      toggle_t_q <= '0;
      detect_t_q <= '0;
      test_t_q   <= '0;
      update_t_q <= '0;
      led_q      <= LedDark;
    end else if (step_i) begin
      mode_q     <= mode_d;
      on_pend_q  <= on_pend_d;
      off_pend_q <= off_pend_d;
      sel_q      <= sel_d;
      toggle_t_q <= toggle_t_d;
      detect_t_q <= detect_t_d;
      test_t_q   <= test_t_d;
      update_t_q <= update_t_d;
      led_q      <= led_d;
    end
  end

  assign result_o.red         = led_d[23:16];
  assign result_o.green       = led_d[15:8];
  assign result_o.blue        = led_d[7:0];
  assign result_o.alarm_state = mode_code(mode_d);

endmodule

### sv/proximity_alarm_blinker.sv
// top level of the proximity alarm blinker: input register, core, result register
// depends on pab_pkg, pab_cfg_regs and pab_core
//
// usage
//   input channel: in_valid_i / in_stall_o / in_beat_i. a beat is a command
//   (turn on, turn off, start test) or an update with a ms timestamp and a
//   distance sample. every beat yields exactly one result beat.
//   output channel: out_valid_o / out_stall_i / out_beat_o carry the led
//   levels and alarm state after that beat.
//   configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i;
//   write only while no beat is in flight.
// timing
//   an accepted beat is held in the input register, the core's next-state
//   logic turns it into a result and the output register captures that. one
//   beat per cycle is sustained while out_stall_i stays low.
// reset
//   the alarm starts off with the led dark, no requests pending, all times
//   zero and the configuration at its default values.
// stall
//   a stalled result holds in the output register; the input register keeps
//   accepting until it is full behind it, then in_stall_o rises.

module proximity_alarm_blinker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pab_pkg::in_beat_t             in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pab_pkg::out_beat_t            out_beat_o,
  input  logic                          cfg_we_i,
  input  logic [pab_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [pab_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import pab_pkg::*;

  logic      in_valid_q, in_valid_d;
  in_beat_t  in_beat_q;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q;
  logic      accept, advance;
  cfg_t      cfg;
  out_beat_t result;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_beat_q <= in_beat_i;
    end
    if (advance) begin
      out_beat_q <= result;
    end
  end

  pab_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pab_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .beat_i   (in_beat_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

### tb/testbench.sv
// self-checking testbench for proximity_alarm_blinker: directed and random beats,
// random idling on both channels, a scoreboard class that predicts every result
// depends on pab_pkg and proximity_alarm_blinker
`timescale 1ns / 1ps

module testbench;
  import pab_pkg::*;

  localparam int StuckLimit = 1000;
  localparam int RandomBeats = 1600;
  localparam int NumPhases = 6;

  class alarm_scoreboard;
    cfg_t               regs;
    logic [1:0]         mode;
    logic               want_on;
    logic               want_off;
    logic               use_b;
    logic [TimeW-1:0]   toggled_at;
    logic [TimeW-1:0]   detected_at;
    logic [TimeW-1:0]   test_from;
    logic [TimeW-1:0]   updated_at;
    logic [ColourW-1:0] led;
    out_beat_t          expected_leds[$];
    int                 errors;
    int                 n_checked;
    int                 seen[4];

    function new();
      regs = '{ColourAReset, ColourBReset, BlinkReset, TriggerReset, TimeoutReset};
      mode = StateOff;
      want_on = 1'b0;
      want_off = 1'b0;
      use_b = 1'b0;
      toggled_at = '0;
      detected_at = '0;
      test_from = '0;
      updated_at = '0;
      led = LedDark;
      errors = 0;
      n_checked = 0;
      seen = '{0, 0, 0, 0};
    endfunction

    function logic [TimeW-1:0] age(logic [TimeW-1:0] now, logic [TimeW-1:0] since);
      return now - since;
    endfunction

    function void apply_update(logic [TimeW-1:0] now, logic [DistW-1:0] sample);
      updated_at = now;
      if (want_on) mode = StateWatch;
      if (want_off) mode = StateOff;
      want_on = 1'b0;
      want_off = 1'b0;
      case (mode)
        StateOff: begin
          led = LedDark;
        end
        StateWatch: begin
          if (sample <= regs.trigger_distance) begin
            mode = StateOn;
            detected_at = now;
          end
        end
        StateOn: begin
          if (age(now, toggled_at) >= regs.blink_period_ms) begin
            use_b = !use_b;
            led = use_b ? regs.colour_b : regs.colour_a;
            toggled_at = now;
          end
          if (sample > regs.trigger_distance) begin
            if (age(now, detected_at) >= regs.clear_timeout_ms) begin
              mode = StateWatch;
              led = LedDark;
            end
          end else begin
            detected_at = now;
          end
        end
        default: begin
          led = LedYellow;
          if (age(now, test_from) >= TestDurationMs) begin
            mode = StateWatch;
            led = LedDark;
          end
        end
      endcase
    endfunction

    // accepted input beat: advance the predicted alarm and queue its result
    function void note(in_beat_t b);
      out_beat_t e;
      case (b.kind)
        KIND_UPDATE: apply_update(b.now_ms, b.distance);
        KIND_ON:     want_on = 1'b1;
        KIND_OFF:    want_off = 1'b1;
        default: begin
          mode = StateTest;
          test_from = updated_at;
        end
      endcase
      e.red = led[23:16];
      e.green = led[15:8];
      e.blue = led[7:0];
      e.alarm_state = mode;
      expected_leds.push_back(e);
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", n_checked, name, got, want));
    endfunction

    function void check(out_beat_t got);
      out_beat_t want;
      if (expected_leds.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_leds.pop_front();
      cmp_field("red", got.red, want.red);
      cmp_field("green", got.green, want.green);
      cmp_field("blue", got.blue, want.blue);
      cmp_field("alarm_state", 8'(got.alarm_state), 8'(want.alarm_state));
      seen[want.alarm_state]++;
      n_checked++;
    endfunction

    function void set_regs(cfg_t c);
      regs = c;
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_beat_o;
  logic      cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  alarm_scoreboard sb;
  int  stuck;
  int  sent_n;
  int  settings_n;
  bit  idling;
  logic [TimeW-1:0] clock_ms;
  bit  near;

  proximity_alarm_blinker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    stuck = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck <= 0;
      else stuck <= stuck + 1;
      if (in_valid_i && !in_stall_o) sb.note(in_beat_i);
      if (out_valid_o && !out_stall_i) sb.check(out_beat_o);
    end
  end

  initial begin
    while (stuck < StuckLimit) @(posedge clk_i);
    $display("timeout: no beat moved for %0d cycles", StuckLimit);
    $display("proximity_alarm_blinker regression: fail");
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      if (idling) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic in_beat_t mk(kind_e k, logic [TimeW-1:0] now,
                                  logic [DistW-1:0] sample);
    in_beat_t b;
    b.kind = k;
    b.now_ms = now;
    b.distance = sample;
    return b;
  endfunction

  task automatic send_beat(in_beat_t b);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_n++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.n_checked != sent_n) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(cfg_t c);
    logic [CfgDataW-1:0] v;
    for (int i = 0; i < 5; i++) begin
      case (cfg_reg_e'(i))
        CFG_COLOUR_A: v = CfgDataW'(c.colour_a);
        CFG_COLOUR_B: v = CfgDataW'(c.colour_b);
        CFG_BLINK:    v = c.blink_period_ms;
        CFG_TRIGGER:  v = CfgDataW'(c.trigger_distance);
        default:      v = c.clear_timeout_ms;
      endcase
      cfg_we_i <= 1'b1;
      cfg_addr_i <= CfgAddrW'(i);
      cfg_wdata_i <= v;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    sb.set_regs(c);
    settings_n++;
  endtask

  task automatic directed_beats();
    in_beat_t seq[$];
    seq.push_back(mk(KIND_UPDATE, 32'd0, 16'd0));
    seq.push_back(mk(KIND_TEST, 32'hFFFF_FFFF, 16'hFFFF));
    seq.push_back(mk(KIND_UPDATE, 32'd1000, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'd2999, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'd3000, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'd3100, 16'hFFFF));
    seq.push_back(mk(KIND_UPDATE, 32'd3200, 16'd1600));
    seq.push_back(mk(KIND_UPDATE, 32'd3300, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'd3549, 16'd1600));
    seq.push_back(mk(KIND_UPDATE, 32'd3550, 16'd100));
    seq.push_back(mk(KIND_UPDATE, 32'd3600, 16'd1601));
    seq.push_back(mk(KIND_UPDATE, 32'd6549, 16'd1601));
    seq.push_back(mk(KIND_UPDATE, 32'd6550, 16'hFFFF));
    // both requests pending: off wins
    seq.push_back(mk(KIND_ON, 32'd0, 16'd0));
    seq.push_back(mk(KIND_OFF, 32'hFFFF_FFFF, 16'hFFFF));
    seq.push_back(mk(KIND_UPDATE, 32'd7000, 16'd0));
    seq.push_back(mk(KIND_ON, 32'd0, 16'd0));
    seq.push_back(mk(KIND_TEST, 32'd0, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'd7100, 16'hFFFF));
    // time wrap while on
    seq.push_back(mk(KIND_UPDATE, 32'hFFFF_FF00, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'h0000_0010, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'hFFFF_FFFF, 16'hFFFF));
    seq.push_back(mk(KIND_OFF, 32'd0, 16'd0));
    seq.push_back(mk(KIND_TEST, 32'd0, 16'd0));
    seq.push_back(mk(KIND_UPDATE, 32'h5555_AAAA, 16'h5A5A));
    foreach (seq[i]) send_beat(seq[i]);
    drain();
  endtask

  function automatic logic [DistW-1:0] pick_distance();
    logic [DistW-1:0] trig;
    trig = sb.regs.trigger_distance;
    if ($urandom_range(0, 99) < 8) return DistW'($urandom);
    if (near || trig == '1) return DistW'($urandom_range(0, trig));
    return DistW'($urandom_range(int'(trig) + 1, 65535));
  endfunction

  task automatic random_beats(int count);
    int r;
    in_beat_t b;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) b = mk(KIND_ON, TimeW'($urandom), DistW'($urandom));
      else if (r < 9) b = mk(KIND_OFF, TimeW'($urandom), DistW'($urandom));
      else if (r < 13) b = mk(KIND_TEST, TimeW'($urandom), DistW'($urandom));
      else begin
        r = $urandom_range(0, 99);
        if (r < 4) clock_ms = TimeW'($urandom);
        else if (r < 14) clock_ms += TimeW'($urandom_range(0, 4000));
        else clock_ms += TimeW'($urandom_range(0, 400));
        if ($urandom_range(0, 9) == 0) near = !near;
        b = mk(KIND_UPDATE, clock_ms, pick_distance());
      end
      send_beat(b);
    end
    drain();
  endtask

  function automatic cfg_t phase_regs(int p);
    cfg_t c;
    case (p)
      0: c = '{24'hFFFFFF, 24'h000000, 32'd0, 16'd0, 32'd0};
      1: c = '{ColourW'($urandom), ColourW'($urandom), 32'hFFFF_FFFF, 16'hFFFF,
               32'hFFFF_FFFF};
      2: c = '{24'h000000, 24'hFFFFFF, 32'd1, 16'd1, 32'd1};
      NumPhases - 1: c = '{ColourAReset, ColourBReset, BlinkReset, TriggerReset,
                           TimeoutReset};
      default: c = '{ColourW'($urandom), ColourW'($urandom),
                     TimeW'($urandom_range(0, 600)), DistW'($urandom),
                     TimeW'($urandom_range(0, 3000))};
    endcase
    return c;
  endfunction

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    idling = 1'b1;
    sent_n = 0;
    settings_n = 1;
    clock_ms = '0;
    near = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_beats();
    for (int p = 0; p < NumPhases; p++) begin
      program_regs(phase_regs(p));
      if (p == NumPhases - 1) idling = 1'b0;
      random_beats(RandomBeats / NumPhases);
    end
    if (sb.expected_leds.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_leds.size()));
    $display("covered %0d beats under %0d register settings", sent_n, settings_n);
    $display("results by state: off %0d, watching %0d, on %0d, testing %0d",
             sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
    if (sb.errors == 0) begin
      $display("proximity_alarm_blinker regression: pass");
    end else begin
      $display("proximity_alarm_blinker regression: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/pab_pkg.sv
sv/pab_cfg_regs.sv
sv/pab_core.sv
sv/proximity_alarm_blinker.sv
tb/testbench.sv
